// ----- rtl/stk_pkg.sv -----
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants for the three-stack block
// command codes, field widths and the controller/datapath handshake structs
// ----------------------------------------------------------------------------
package stk_pkg;

    // number of interleaved stacks in the shared store
    localparam int NUM_STACKS = 3;

    // field widths
    localparam int CMD_W   = 2;
    localparam int SEL_W   = 2;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 9;

    // stream bus widths, padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_CAPACITY = 1'b0;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } stk_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } stk_sts_t;

endpackage

// ----- rtl/stk_ram.sv -----
// ----------------------------------------------------------------------------
// stk_ram: generic single-port RAM
// one access per cycle, registered read data that holds until the next read
// ----------------------------------------------------------------------------
module stk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write or read one word
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/stk_ctrl.sv -----
// ----------------------------------------------------------------------------
// stk_ctrl: sequencing controller
// takes one beat, runs it through execute and output load, then goes idle
// ----------------------------------------------------------------------------
module stk_ctrl
    import stk_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  stk_sts_t  sts,
    output stk_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands to the datapath
    assign s_tready     = (state_reg == S_IDLE);
    assign cmd.load_in  = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.exec     = (state_reg == S_EXEC);
    assign cmd.load_out = (state_reg == S_LOAD) && sts.out_free;

endmodule

// ----- rtl/stk_datapath.sv -----
// ----------------------------------------------------------------------------
// stk_datapath: stack counters, shared store and output register
// stack k keeps its level i entry at word 3*i+k of the shared RAM
// ----------------------------------------------------------------------------
module stk_datapath
    import stk_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  stk_cmd_t           cmd,
    output stk_sts_t           sts,
    input  logic [CAP_W-1:0]   capacity,
    input  logic [CMD_W-1:0]   in_cmd,
    input  logic [SEL_W-1:0]   in_sel,
    input  logic [VALUE_W-1:0] in_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] out_read_value,
    output logic               out_hit,
    output logic               out_now_empty
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int WORDS  = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W = $clog2(WORDS);

    // latched input beat
    logic [CMD_W-1:0]   cmd_reg;
    logic [SEL_W-1:0]   sel_reg;
    logic [VALUE_W-1:0] value_reg;

    // per-stack entry counts
    logic [CNT_W-1:0] count_reg [NUM_STACKS];

    // execute results waiting for read data
    logic hit_reg;
    logic empty_reg;
    logic rd_used_reg;

    // output register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_hit_reg;
    logic               out_empty_reg;

    // execute stage decode
    logic               sel_ok;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   cnt_next;
    logic [CNT_W-1:0]   level;
    logic               push_ok;
    logic               read_ok;
    logic               is_pop;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] ram_rdata;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg   <= in_cmd;
            sel_reg   <= in_sel;
            value_reg <= in_value;
        end
    end

    // count lookup, full/empty checks and slot address
    always_comb begin
        sel_ok  = (sel_reg < SEL_W'(NUM_STACKS));
        cnt     = sel_ok ? count_reg[sel_reg] : '0;
        push_ok = sel_ok && (cmd_reg == CMD_PUSH)
                  && (CMP_W'(cnt) < CMP_W'(capacity))
                  && (cnt < CNT_W'(STACK_DEPTH));
        read_ok = sel_ok && ((cmd_reg == CMD_POP) || (cmd_reg == CMD_PEEK))
                  && (cnt != '0);
        is_pop  = (cmd_reg == CMD_POP);
        level   = push_ok ? cnt : cnt - CNT_W'(1);
        addr    = ADDR_W'({level, 1'b0}) + ADDR_W'(level) + ADDR_W'(sel_reg);
        cnt_next = cnt;
        if (push_ok) begin
            cnt_next = cnt + CNT_W'(1);
        end else if (read_ok && is_pop) begin
            cnt_next = cnt - CNT_W'(1);
        end
    end

    // counter update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (cmd.exec && sel_ok) begin
            count_reg[sel_reg] <= cnt_next;
        end
    end

    // flags carried to the output load
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            hit_reg     <= push_ok || read_ok;
            empty_reg   <= sel_ok && (cnt_next == '0);
            rd_used_reg <= read_ok;
        end
    end

    // shared store
    stk_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (WORDS)
    ) u_ram (
        .aclk  (aclk),
        .en    (cmd.exec && (push_ok || read_ok)),
        .we    (push_ok),
        .addr  (addr),
        .wdata (value_reg),
        .rdata (ram_rdata)
    );

    // output register, refilled when empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_value_reg <= rd_used_reg ? ram_rdata : '1;
            out_hit_reg   <= hit_reg;
            out_empty_reg <= empty_reg;
        end
    end

    assign sts.out_free    = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_read_value  = out_value_reg;
    assign out_hit         = out_hit_reg;
    assign out_now_empty   = out_empty_reg;

endmodule

// ----- rtl/three_stacks_shared_memory.sv -----
// ----------------------------------------------------------------------------
// three_stacks_shared_memory: three LIFO stacks interleaved in one RAM
// stream in commands, stream out one result beat per command
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one command beat (push, pop or peek) for stack 0, 1 or 2.
//   m_ channel: exactly one result beat per command, in command order:
//     read value (all ones unless a pop/peek found data), hit, now_empty.
//   APB port: register 0 at byte address 0 holds the per-stack capacity;
//     write it only while no command is in flight.
// Sequencing
//   a command beat is latched while idle; the execute state looks up the
//   count and accesses the RAM, whose registered read data is ready at
//   the end of it; the output load state then loads the output register.
//   a new command is taken only once the previous one has passed output
//   load and the controller is back in idle; the next command is taken
//   while the previous result still waits in the output register.
// Reset
//   all stacks empty, capacity 256, no result pending; RAM contents are
//   not cleared and need no clearing pass.
// Stall
//   if m_tready stays low, the result holds and at most one further
//   command is taken; s_tready then stays low until the result drains.
// ----------------------------------------------------------------------------
module three_stacks_shared_memory
    import stk_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // cmd [1:0], stack_select [3:2], push_value [35:4], zero pad [39:36]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // read_value [31:0], hit [32], now_empty [33], zero pad [39:34]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [CAP_W-1:0]   capacity_reg;
    stk_cmd_t           cmd;
    stk_sts_t           sts;
    logic [VALUE_W-1:0] read_value;
    logic               hit;
    logic               now_empty;
    logic               reg_sel;

    // configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_IDX_CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(capacity_reg) : '0;

    // sequencing
    stk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // stacks and output register
    stk_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .capacity       (capacity_reg),
        .in_cmd         (s_tdata[1:0]),
        .in_sel         (s_tdata[3:2]),
        .in_value       (s_tdata[35:4]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_read_value (read_value),
        .out_hit        (hit),
        .out_now_empty  (now_empty)
    );

    assign m_tdata = {6'd0, now_empty, hit, read_value};

endmodule

// ----- rtl/stk_checker.sv -----
// ----------------------------------------------------------------------------
// stk_checker: port-level checks for the three-stack block
// result beat rules and the one-command-at-a-time sequencing
// ----------------------------------------------------------------------------
module stk_checker
    import stk_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // a miss always reports all ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'hFFFF_FFFF)
        else $error("miss without all-ones value");

    // after taking a command the block is busy for the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while busy");

    // no result pending right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind three_stacks_shared_memory stk_checker u_stk_checker (.*);
